>>> rtl/core/pese_pkg.sv
// package: shared types and constants for the prefix expression stack evaluator
package pese_pkg;

   localparam logic [7:0] SYM_ADD  = 8'h2B;
   localparam logic [7:0] SYM_SUB  = 8'h2D;
   localparam logic [7:0] SYM_MUL  = 8'h2A;
   localparam logic [7:0] SYM_DIV  = 8'h2F;
   localparam logic [7:0] SYM_MOD  = 8'h25;
   localparam logic [7:0] SYM_ZERO = 8'h30;

   typedef enum logic [1:0] {
      CMD_HOLD = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_POP  = 2'd2
   } stack_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_POP_A  = 4'd1,
      ST_POP_B  = 4'd2,
      ST_CALC   = 4'd3,
      ST_MUL    = 4'd4,
      ST_DIV    = 4'd5,
      ST_FIX    = 4'd6,
      ST_PUSH   = 4'd7,
      ST_FINPOP = 4'd8,
      ST_OUT    = 4'd9
   } state_type;

   // divider control, carried as one group
   typedef struct packed {
      logic start;
   } div_ctl_type;

endpackage

>>> rtl/core/pese_cell.sv
// file: one stack cell, shifts toward its neighbours on push and pop
module pese_cell (
   input  logic                   clock,
   input  pese_pkg::stack_cmd_type cmd,
   input  logic [31:0]            from_above,
   input  logic [31:0]            from_below,
   output logic [31:0]            value
);
   import pese_pkg::*;

   logic [31:0] value_ff;
   logic [31:0] value_in;

   always_comb begin
      unique case (cmd)
         CMD_PUSH: value_in = from_above;
         CMD_POP:  value_in = from_below;
         default:  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

>>> rtl/core/pese_div.sv
// file: radix-2 restoring divider on 32-bit magnitudes
module pese_div (
   input  logic                   clock,
   input  logic                   reset,
   input  pese_pkg::div_ctl_type  ctl,
   input  logic [31:0]            dividend,
   input  logic [31:0]            divisor,
   output logic                   done,
   output logic [31:0]            quotient,
   output logic [31:0]            remainder
);
   import pese_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
         end
         quo_in = {quo_ff[30:0], ~trial[32]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = busy_ff && (cnt_ff == 6'd1);
   assign quotient  = quo_in;
   assign remainder = rem_in;
endmodule

>>> rtl/core/prefix_expression_stack_evaluator.sv
// file: top level of the prefix expression stack evaluator
// Takes a prefix expression one byte word at a time, last character first,
// and returns the value with sticky error flags on the word marked final.
// The operand stack is a chain of STACK_DEPTH identical cells that all shift
// one place on a push or a pop, so the top is always in cell zero. Each word
// is handled by a sequencer one word at a time: an operand goes through push,
// + and - through pop A, pop B, calc and push, * adds a multiply step, / and
// % add a wait on the 32-step radix-2 divider and a sign fix-up (both skipped
// with a zero divisor), and the final word adds a final pop and hand-off. The
// result sits in an output register until taken while later words go on; the
// sequencer only waits at hand-off while the previous result is still held.
module prefix_expression_stack_evaluator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   input  logic               req_final_symbol,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_underflow_seen,
   output logic               rsp_overflow_seen,
   output logic               rsp_divide_by_zero_seen
);
   import pese_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   state_type     state_ff, state_in;
   stack_cmd_type cmd;
   logic [31:0]   push_val;
   logic [31:0]   cell_val [STACK_DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    flags_ff, flags_in;   // underflow, overflow, divide by zero
   logic [7:0]    sym_ff;
   logic          fin_ff;
   logic [31:0]   a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [31:0]   prod;
   logic          rvalid_ff, rvalid_in;
   logic [31:0]   rval_ff, rval_in;
   logic [2:0]    rflag_ff, rflag_in;

   div_ctl_type   dctl;
   logic          ddone;
   logic [31:0]   dquo, drem, mag_a, mag_b;

   // operand signs and divider magnitudes held for the sign fix-up
   logic          sa_ff, sb_ff;
   logic [31:0]   q_mag_ff, r_mag_ff;
   logic [31:0]   fix_res;

   logic is_op;
   assign is_op = (req_symbol == SYM_ADD) || (req_symbol == SYM_SUB) ||
                  (req_symbol == SYM_MUL) || (req_symbol == SYM_DIV) ||
                  (req_symbol == SYM_MOD);

   // the cell chain, cell zero holds the top
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [31:0] above, below;
      if (i == 0) begin : g_top
         assign above = push_val;
      end else begin : g_mid
         assign above = cell_val[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign below = cell_val[i];
      end else begin : g_up
         assign below = cell_val[i+1];
      end
      pese_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .from_above(above),
         .from_below(below),
         .value     (cell_val[i])
      );
   end

   assign mag_a = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign mag_b = b_ff[31] ? (32'd0 - b_ff) : b_ff;

   pese_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .dividend (mag_a),
      .divisor  (mag_b),
      .done     (ddone),
      .quotient (dquo),
      .remainder(drem)
   );

   // remainder follows the dividend, quotient negative when signs differ
   assign fix_res = (sym_ff == SYM_MOD) ? (sa_ff ? 32'd0 - r_mag_ff : r_mag_ff)
                                        : ((sa_ff != sb_ff) ? 32'd0 - q_mag_ff : q_mag_ff);

   assign req_stall = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               state_in = is_op ? ST_POP_A : ST_PUSH;
            end
         end
         ST_POP_A: state_in = ST_POP_B;
         ST_POP_B: state_in = ST_CALC;
         ST_CALC: begin
            priority if (sym_ff == SYM_MUL) begin
               state_in = ST_MUL;
            end else if ((sym_ff == SYM_DIV || sym_ff == SYM_MOD) && b_ff != 32'd0) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_MUL: state_in = ST_PUSH;
         ST_DIV: if (ddone) state_in = ST_FIX;
         ST_FIX: state_in = ST_PUSH;
         ST_PUSH: state_in = fin_ff ? ST_FINPOP : ST_IDLE;
         ST_FINPOP: state_in = ST_OUT;
         ST_OUT: if (!rvalid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd       = CMD_HOLD;
      push_val  = r_ff;
      count_in  = count_ff;
      flags_in  = flags_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      r_in      = r_ff;
      dctl      = '0;
      rvalid_in = rvalid_ff && rsp_stall;
      rval_in   = rval_ff;
      rflag_in  = rflag_ff;
      prod      = a_ff * b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            r_in = 32'(req_symbol) - 32'(SYM_ZERO);
         end
         ST_POP_A, ST_POP_B, ST_FINPOP: begin
            if (count_ff == '0) begin
               flags_in[0] = 1'b1;
               if (state_ff == ST_POP_A) a_in = '0;
               else if (state_ff == ST_POP_B) b_in = '0;
               else r_in = '0;
            end else begin
               cmd      = CMD_POP;
               count_in = count_ff - CW'(1);
               if (state_ff == ST_POP_A) a_in = cell_val[0];
               else if (state_ff == ST_POP_B) b_in = cell_val[0];
               else r_in = cell_val[0];
            end
         end
         ST_CALC: begin
            priority if (sym_ff == SYM_ADD) begin
               r_in = a_ff + b_ff;
            end else if (sym_ff == SYM_SUB) begin
               r_in = a_ff - b_ff;
            end else if (sym_ff == SYM_MUL) begin
               r_in = r_ff;
            end else if (b_ff == 32'd0) begin
               flags_in[2] = 1'b1;
               r_in = '0;
            end else begin
               dctl.start = 1'b1;
            end
         end
         ST_MUL: r_in = prod;
         ST_FIX: r_in = fix_res;
         ST_PUSH: begin
            if (count_ff >= FULL) begin
               flags_in[1] = 1'b1;
            end else begin
               cmd      = CMD_PUSH;
               count_in = count_ff + CW'(1);
            end
         end
         ST_OUT: begin
            // hand off once the output register is free or being emptied
            if (!rvalid_ff || !rsp_stall) begin
               rvalid_in = 1'b1;
               rval_in   = r_ff;
               rflag_in  = flags_ff;
               flags_in  = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         flags_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         flags_ff  <= flags_in;
         rvalid_ff <= rvalid_in;
      end
      if (state_ff == ST_IDLE) begin
         sym_ff <= req_symbol;
         fin_ff <= req_final_symbol;
      end
      if (state_ff == ST_CALC) begin
         sa_ff <= a_ff[31];
         sb_ff <= b_ff[31];
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      r_ff     <= r_in;
      rval_ff  <= rval_in;
      rflag_ff <= rflag_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && ddone) begin
         q_mag_ff <= dquo;
         r_mag_ff <= drem;
      end
   end

   assign rsp_valid               = rvalid_ff;
   assign rsp_value               = rval_ff;
   assign rsp_underflow_seen      = rflag_ff[0];
   assign rsp_overflow_seen       = rflag_ff[1];
   assign rsp_divide_by_zero_seen = rflag_ff[2];

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |=> (r_ff == $past(fix_res)))
      else $error("divide fix-up result lost");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("stack count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> rsp_valid)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled result word changed");
endmodule
